// ----- src/sst_pkg.sv -----
// Shared types and constants for the sweep scanner hit table.
// No dependencies; imported by sst_cell and sweep_scanner_hit_table.
package sst_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 32;
   localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

   // Field widths
   localparam int FREQ_W  = 30;
   localparam int STEP_W  = 27;
   localparam int COUNT_W = 16;
   localparam int CSR_W   = 30;
   localparam int CSR_IDX_W = 2;

   // Register reset values
   localparam logic [FREQ_W-1:0] START_FREQ_RST = 30'd150000000;
   localparam logic [FREQ_W-1:0] END_FREQ_RST   = 30'd900000000;
   localparam logic [STEP_W-1:0] STEP_FREQ_RST  = 27'd25000;
   localparam logic signed [7:0] THRESHOLD_RST  = -8'sd80;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_FREQ = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_FREQ   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_FREQ  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd3;

   // Request actions
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_STOP  = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   typedef logic [FREQ_W-1:0]  freq_type;
   typedef logic [COUNT_W-1:0] count_type;

   // One table slot as it travels around the ring
   typedef struct packed {
      freq_type  freq;
      count_type count;
   } slot_entry_type;

endpackage

// ----- src/sst_cell.sv -----
// One storage cell of the hit table ring: holds a slot entry and passes
// it to its neighbor on every shift. Depends on sst_pkg.
module sst_cell (
   input  logic                   clock,
   input  logic                   shift,
   input  sst_pkg::slot_entry_type d_entry,
   output sst_pkg::slot_entry_type q_entry
);
   import sst_pkg::*;

   slot_entry_type entry_ff;
   slot_entry_type entry_in;

   // Take the neighbor's entry on shift, hold otherwise
   always_comb begin
      entry_in = shift ? d_entry : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q_entry = entry_ff;

endmodule

// ----- src/sweep_scanner_hit_table.sv -----
// Sweep scanner with a hit table held in a ring of slot cells.
// A non-hit item goes from ST_IDLE to ST_EMIT and into the output register; a hit
// first walks the whole ring in ST_WALK, one slot per cycle, over all TABLE_DEPTH (32) slots.
// Throughput: one item at a time; the ring walk sets the rate for hit ticks.
// Reset (synchronous, active high) restores register defaults, stops scanning,
// empties the table by clearing the fill count; slot contents stay unreset.
module sweep_scanner_hit_table (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_action,
   input  logic signed [7:0]             req_strength_dbm,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sst_pkg::FREQ_W-1:0]    rsp_tuned_freq,
   output logic [sst_pkg::COUNT_W-1:0]   rsp_sweep_count,
   output logic                          rsp_hit,
   output logic [4:0]                    rsp_hit_slot,
   output logic [sst_pkg::COUNT_W-1:0]   rsp_slot_hits,
   output logic                          rsp_table_full_drop,
   // configuration port
   input  logic                          csr_we,
   input  logic [sst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sst_pkg::CSR_W-1:0]     csr_wdata
);
   import sst_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   // Configuration registers
   freq_type              start_freq_ff;
   freq_type              end_freq_ff;
   logic [STEP_W-1:0]     step_freq_ff;
   logic signed [7:0]     threshold_ff;

   // Control and sweep state
   logic [1:0]            state_ff, state_in;
   logic                  scanning_ff, scanning_in;
   freq_type              cur_freq_ff, cur_freq_in;
   count_type             sweeps_ff, sweeps_in;
   logic [USED_W-1:0]     used_ff, used_in;
   logic [SLOT_W-1:0]     walk_idx_ff, walk_idx_in;
   logic                  found_ff, found_in;

   // Pending result fields
   logic                  pend_hit_ff, pend_hit_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   count_type             pend_hits_ff, pend_hits_in;
   logic                  pend_drop_ff, pend_drop_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   freq_type              rsp_freq_ff, rsp_freq_in;
   count_type             rsp_sweeps_ff, rsp_sweeps_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [4:0]            rsp_slot_ff, rsp_slot_in;
   count_type             rsp_hits_ff, rsp_hits_in;
   logic                  rsp_drop_ff, rsp_drop_in;

   // Ring
   slot_entry_type        ring_q [TABLE_DEPTH];
   slot_entry_type        head_new;
   logic                  ring_shift;

   logic                  req_accept;
   logic                  rsp_free;
   logic                  is_hit;
   logic [FREQ_W:0]       freq_sum;
   logic                  wrap;
   freq_type              freq_adv;
   count_type             sweeps_adv;
   logic                  slot_live;
   logic                  slot_match;
   logic                  slot_alloc;
   logic                  walk_last;
   count_type             head_inc;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign ring_shift = (state_ff == ST_WALK);

   // Build the ring of cells, each fed by its right neighbor, last fed by head
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      slot_entry_type d_entry;
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign d_entry = head_new;
      end else begin : g_mid
         assign d_entry = ring_q[i+1];
      end
      sst_cell u_cell (
         .clock   (clock),
         .shift   (ring_shift),
         .d_entry (d_entry),
         .q_entry (ring_q[i])
      );
   end

   // Strength above threshold on a scanning tick
   assign is_hit = scanning_ff && (req_action == ACT_TICK) &&
                   (req_strength_dbm > threshold_ff);

   // Step the frequency and detect wrap at full width
   assign freq_sum   = {1'b0, cur_freq_ff} + {{(FREQ_W + 1 - STEP_W){1'b0}}, step_freq_ff};
   assign wrap       = freq_sum > {1'b0, end_freq_ff};
   assign freq_adv   = wrap ? start_freq_ff : freq_sum[FREQ_W-1:0];
   assign sweeps_adv = wrap ? sweeps_ff + 1'b1 : sweeps_ff;

   // Compare the head slot of the ring against the current frequency
   assign slot_live  = {{(USED_W - SLOT_W){1'b0}}, walk_idx_ff} < used_ff;
   assign slot_match = slot_live && !found_ff && (ring_q[0].freq == cur_freq_ff);
   assign slot_alloc = ({{(USED_W - SLOT_W){1'b0}}, walk_idx_ff} == used_ff) && !found_ff;
   assign walk_last  = (walk_idx_ff == SLOT_W'(TABLE_DEPTH - 1));
   assign head_inc   = (ring_q[0].count == COUNT_MAX) ? COUNT_MAX
                                                      : ring_q[0].count + 1'b1;

   // Update the head entry as it wraps to the tail
   always_comb begin
      head_new = ring_q[0];
      if (slot_match) begin
         head_new.count = head_inc;
      end else if (slot_alloc) begin
         head_new.freq  = cur_freq_ff;
         head_new.count = count_type'(1);
      end
   end

   // Sequence the items
   always_comb begin
      state_in     = state_ff;
      scanning_in  = scanning_ff;
      cur_freq_in  = cur_freq_ff;
      sweeps_in    = sweeps_ff;
      used_in      = used_ff;
      walk_idx_in  = walk_idx_ff;
      found_in     = found_ff;
      pend_hit_in  = pend_hit_ff;
      pend_slot_in = pend_slot_ff;
      pend_hits_in = pend_hits_ff;
      pend_drop_in = pend_drop_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_freq_in  = rsp_freq_ff;
      rsp_sweeps_in = rsp_sweeps_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_hits_in  = rsp_hits_ff;
      rsp_drop_in  = rsp_drop_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               pend_hit_in  = 1'b0;
               pend_slot_in = '0;
               pend_hits_in = '0;
               pend_drop_in = 1'b0;
               state_in     = ST_EMIT;
               case (req_action)
                  ACT_START: begin
                     scanning_in = 1'b1;
                     sweeps_in   = '0;
                     cur_freq_in = start_freq_ff;
                  end
                  ACT_STOP: begin
                     scanning_in = 1'b0;
                  end
                  ACT_CLEAR: begin
                     used_in = '0;
                  end
                  default: begin
                     if (is_hit) begin
                        walk_idx_in = '0;
                        found_in    = 1'b0;
                        pend_hit_in = 1'b1;
                        state_in    = ST_WALK;
                     end else if (scanning_ff) begin
                        cur_freq_in = freq_adv;
                        sweeps_in   = sweeps_adv;
                     end
                  end
               endcase
            end
         end
         ST_WALK: begin
            walk_idx_in = walk_idx_ff + 1'b1;
            if (slot_match) begin
               found_in     = 1'b1;
               pend_slot_in = walk_idx_ff;
               pend_hits_in = head_inc;
            end else if (slot_alloc) begin
               found_in     = 1'b1;
               pend_slot_in = walk_idx_ff;
               pend_hits_in = count_type'(1);
               used_in      = used_ff + 1'b1;
            end
            if (walk_last) begin
               pend_drop_in = !found_ff && !slot_match && !slot_alloc;
               cur_freq_in  = freq_adv;
               sweeps_in    = sweeps_adv;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_freq_in   = cur_freq_ff;
               rsp_sweeps_in = sweeps_ff;
               rsp_hit_in    = pend_hit_ff;
               rsp_slot_in   = 5'(pend_slot_ff);
               rsp_hits_in   = pend_hits_ff;
               rsp_drop_in   = pend_drop_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scanning_ff   <= 1'b0;
         cur_freq_ff   <= START_FREQ_RST;
         sweeps_ff     <= '0;
         used_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         start_freq_ff <= START_FREQ_RST;
         end_freq_ff   <= END_FREQ_RST;
         step_freq_ff  <= STEP_FREQ_RST;
         threshold_ff  <= THRESHOLD_RST;
      end else begin
         state_ff     <= state_in;
         scanning_ff  <= scanning_in;
         cur_freq_ff  <= cur_freq_in;
         sweeps_ff    <= sweeps_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         // Decode configuration writes
         if (csr_we) begin
            unique case (csr_index)
               CSR_START_FREQ: start_freq_ff <= csr_wdata[FREQ_W-1:0];
               CSR_END_FREQ:   end_freq_ff   <= csr_wdata[FREQ_W-1:0];
               CSR_STEP_FREQ:  step_freq_ff  <= csr_wdata[STEP_W-1:0];
               CSR_THRESHOLD:  threshold_ff  <= $signed(csr_wdata[7:0]);
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      walk_idx_ff   <= walk_idx_in;
      found_ff      <= found_in;
      pend_hit_ff   <= pend_hit_in;
      pend_slot_ff  <= pend_slot_in;
      pend_hits_ff  <= pend_hits_in;
      pend_drop_ff  <= pend_drop_in;
      rsp_freq_ff   <= rsp_freq_in;
      rsp_sweeps_ff <= rsp_sweeps_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_hits_ff   <= rsp_hits_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_tuned_freq      = rsp_freq_ff;
   assign rsp_sweep_count     = rsp_sweeps_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_hit_slot        = rsp_slot_ff;
   assign rsp_slot_hits       = rsp_hits_ff;
   assign rsp_table_full_drop = rsp_drop_ff;

endmodule

// ----- tb/sweep_scanner_hit_table_check.sv -----
// Result checker for the sweep scanner hit table: watches the request, result and
// register ports, predicts every result word and compares it field by field.
// Depends on sst_pkg for widths, register indexes, actions and reset values.
module sweep_scanner_hit_table_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic signed [7:0]              req_strength_dbm,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [sst_pkg::FREQ_W-1:0]     rsp_tuned_freq,
   input  logic [sst_pkg::COUNT_W-1:0]    rsp_sweep_count,
   input  logic                           rsp_hit,
   input  logic [4:0]                     rsp_hit_slot,
   input  logic [sst_pkg::COUNT_W-1:0]    rsp_slot_hits,
   input  logic                           rsp_table_full_drop,
   input  logic                           csr_we,
   input  logic [sst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sst_pkg::CSR_W-1:0]      csr_wdata,
   output int                             mismatch_total,
   output int                             words_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import sst_pkg::*;

   typedef struct packed {
      freq_type   tuned_freq;
      count_type  sweep_count;
      logic       hit;
      logic [4:0] hit_slot;
      count_type  slot_hits;
      logic       full_drop;
   } sweep_outcome_type;

   // Register copies
   freq_type           cfg_start;
   freq_type           cfg_end;
   logic [STEP_W-1:0]  cfg_step;
   logic signed [7:0]  cfg_thr;

   // Scanner and table state
   logic               scanning;
   freq_type           cur_freq;
   count_type          sweeps;
   int                 slots_used;
   freq_type           slot_freq  [TABLE_DEPTH];
   count_type          slot_hits  [TABLE_DEPTH];

   sweep_outcome_type  predicted [$];
   int                 errors;

   // Apply one request word to the state and return the result it yields
   function automatic sweep_outcome_type predict_word(logic [1:0] action,
                                                      logic signed [7:0] strength);
      sweep_outcome_type o;
      logic [FREQ_W:0]   next_freq;
      int                slot;
      o    = '0;
      slot = -1;
      case (action)
         ACT_START: begin
            scanning = 1'b1;
            sweeps   = '0;
            cur_freq = cfg_start;
         end
         ACT_STOP:  scanning = 1'b0;
         ACT_CLEAR: slots_used = 0;
         ACT_TICK: begin
            if (scanning) begin
               if (strength > cfg_thr) begin
                  o.hit = 1'b1;
                  // look up the first slot holding this frequency
                  for (int i = 0; i < slots_used; i++)
                     if (slot < 0 && slot_freq[i] == cur_freq) slot = i;
                  if (slot >= 0) begin
                     if (slot_hits[slot] != COUNT_MAX) slot_hits[slot]++;
                  end else if (slots_used < TABLE_DEPTH) begin
                     slot            = slots_used;
                     slot_freq[slot] = cur_freq;
                     slot_hits[slot] = count_type'(1);
                     slots_used++;
                  end
                  if (slot >= 0) begin
                     o.hit_slot  = slot[4:0];
                     o.slot_hits = slot_hits[slot];
                  end else begin
                     o.full_drop = 1'b1;
                  end
               end
               // advance at full width, wrap past the end
               next_freq = {1'b0, cur_freq} + (FREQ_W+1)'(cfg_step);
               if (next_freq > {1'b0, cfg_end}) begin
                  cur_freq = cfg_start;
                  sweeps++;
               end else begin
                  cur_freq = next_freq[FREQ_W-1:0];
               end
            end
         end
      endcase
      o.tuned_freq  = cur_freq;
      o.sweep_count = sweeps;
      return o;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t check: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      sweep_outcome_type want;
      if (reset) begin
         cfg_start  = START_FREQ_RST;
         cfg_end    = END_FREQ_RST;
         cfg_step   = STEP_FREQ_RST;
         cfg_thr    = THRESHOLD_RST;
         scanning   = 1'b0;
         cur_freq   = START_FREQ_RST;
         sweeps     = '0;
         slots_used = 0;
         predicted.delete();
      end else begin
         // track register writes
         if (csr_we) begin
            case (csr_index)
               CSR_START_FREQ: cfg_start = csr_wdata[FREQ_W-1:0];
               CSR_END_FREQ:   cfg_end   = csr_wdata[FREQ_W-1:0];
               CSR_STEP_FREQ:  cfg_step  = csr_wdata[STEP_W-1:0];
               CSR_THRESHOLD:  cfg_thr   = csr_wdata[7:0];
            endcase
         end
         // predict on each accepted request word
         if (req_valid && !req_stall)
            predicted.push_back(predict_word(req_action, req_strength_dbm));
         // compare each accepted result word with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (predicted.size() == 0) begin
               errors++;
               $display("%0t check: result word with nothing predicted, tuned_freq 0x%0h",
                        $time, rsp_tuned_freq);
            end else begin
               want = predicted.pop_front();
               check_field("tuned_freq", 32'(want.tuned_freq), 32'(rsp_tuned_freq));
               check_field("sweep_count", 32'(want.sweep_count), 32'(rsp_sweep_count));
               check_field("hit", 32'(want.hit), 32'(rsp_hit));
               check_field("hit_slot", 32'(want.hit_slot), 32'(rsp_hit_slot));
               check_field("slot_hits", 32'(want.slot_hits), 32'(rsp_slot_hits));
               check_field("table_full_drop", 32'(want.full_drop),
                           32'(rsp_table_full_drop));
            end
         end
      end
      mismatch_total    <= errors;
      words_outstanding <= predicted.size();
   end

endmodule

// ----- tb/sweep_scanner_hit_table_tb.sv -----
// Top of the sweep scanner hit table testbench: clock, reset, request and register
// stimulus, result stalls, watchdog and verdict.
// Depends on sst_pkg, sweep_scanner_hit_table and sweep_scanner_hit_table_check.
module sweep_scanner_hit_table_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sst_pkg::*;

   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 88;
   localparam int HOLD_CYCLES     = 150;
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_action;
   logic signed [7:0]     req_strength_dbm;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [FREQ_W-1:0]     rsp_tuned_freq;
   logic [COUNT_W-1:0]    rsp_sweep_count;
   logic                  rsp_hit;
   logic [4:0]            rsp_hit_slot;
   logic [COUNT_W-1:0]    rsp_slot_hits;
   logic                  rsp_table_full_drop;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_W-1:0]      csr_wdata;
   int                    mismatch_total;
   int                    words_outstanding;

   bit tx_idle         = 1'b1;
   bit rx_idle         = 1'b1;
   bit rx_hold_pending = 1'b0;

   sweep_scanner_hit_table dut (.*);
   sweep_scanner_hit_table_check hit_table_check (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one request word and hold it until accepted
   task automatic send_word(logic [1:0] action, logic signed [7:0] strength);
      int gap;
      gap = tx_idle ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= action;
      req_strength_dbm <= strength;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Write all four registers; unused upper bits of the threshold carry noise
   task automatic load_settings(freq_type first_hz, freq_type last_hz,
                                logic [CSR_W-1:0] step_word, logic signed [7:0] thr);
      logic [31:0] noise;
      noise = $urandom();
      write_reg(CSR_START_FREQ, first_hz);
      write_reg(CSR_END_FREQ, last_hz);
      write_reg(CSR_STEP_FREQ, step_word);
      write_reg(CSR_THRESHOLD, {noise[21:0], thr});
      csr_we <= 1'b0;
   endtask

   // Result side: random stalls, one long hold-off on request
   initial begin : result_side
      int hold;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_hold_pending) begin
            rx_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         hold = rx_idle ? $urandom_range(0, 8) : 0;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // End the run when no word moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      int                ph;
      int                n;
      int                r;
      int                shape;
      int                span;
      int                step_hz;
      freq_type          base;
      freq_type          last_hz;
      logic [CSR_W-1:0]  step_word;
      logic signed [7:0] thr;
      logic signed [7:0] strength;
      logic [1:0]        act;
      logic [31:0]       noise;
      bit                running;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_action       <= ACT_TICK;
      req_strength_dbm <= '0;
      csr_we           <= 1'b0;
      csr_index        <= CSR_START_FREQ;
      csr_wdata        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Register reset values: tick while stopped, threshold edge, stop
      send_word(ACT_TICK, 8'sd127);
      send_word(ACT_START, 8'sd0);
      send_word(ACT_TICK, -8'sd79);
      send_word(ACT_TICK, -8'sd80);
      send_word(ACT_STOP, 8'sd0);
      send_word(ACT_TICK, 8'sd127);
      settle();

      // Five-frequency sweep: new slots, wrap, match, restart, clear
      load_settings(30'd1000, 30'd1400, 30'd100, -8'sd80);
      send_word(ACT_START, -8'sd128);
      send_word(ACT_TICK, 8'sd127);
      send_word(ACT_TICK, -8'sd80);
      send_word(ACT_TICK, -8'sd79);
      send_word(ACT_TICK, 8'sd127);
      send_word(ACT_TICK, 8'sd127);
      send_word(ACT_TICK, 8'sd127);
      send_word(ACT_START, 8'sd127);
      send_word(ACT_TICK, -8'sd128);
      send_word(ACT_CLEAR, 8'sd0);
      send_word(ACT_TICK, 8'sd127);
      settle();

      // Sum beyond 30 bits wraps; top threshold is never exceeded
      load_settings(30'h3FFF_FF00, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 8'sd127);
      send_word(ACT_START, 8'sd0);
      send_word(ACT_TICK, 8'sd127);
      send_word(ACT_TICK, -8'sd128);
      settle();

      // Zero step: frequency stays, same slot counts up
      load_settings(30'd5, 30'd9, 30'h3800_0000, -8'sd128);
      send_word(ACT_START, 8'sd0);
      send_word(ACT_TICK, -8'sd127);
      send_word(ACT_TICK, 8'sd127);
      settle();

      // New start leaves the current frequency alone; end below start wraps every tick
      load_settings(30'd500, 30'd3, 30'd1, 8'sd0);
      send_word(ACT_STOP, 8'sd0);
      send_word(ACT_START, 8'sd0);
      send_word(ACT_TICK, 8'sd1);
      send_word(ACT_TICK, 8'sd0);
      settle();

      // Random phases, each with its own settings and idling
      for (ph = 0; ph < PHASES; ph++) begin
         tx_idle = ($urandom_range(0, 3) != 0);
         rx_idle = ($urandom_range(0, 3) != 0);
         if (ph == 2) begin
            tx_idle         = 1'b0;
            rx_hold_pending = 1'b1;
         end
         r     = $urandom_range(0, 8);
         shape = (ph == 1) ? 1 : (r < 5) ? 0 : (r < 7) ? 2 : (r < 8) ? 3 : 1;
         noise = $urandom();
         case (shape)
            0, 1: begin
               // short ring of frequencies; shape 1 spans 48 and overflows the table
               span      = (shape == 1) ? 48 : $urandom_range(2, 60);
               step_hz   = $urandom_range(1, 5000);
               base      = FREQ_W'($urandom_range(0, 32'h1FFF_FFFF));
               last_hz   = FREQ_W'(base + step_hz * (span - 1) +
                                   $urandom_range(0, step_hz - 1));
               step_word = {noise[2:0], 27'(step_hz)};
            end
            2: begin
               base      = FREQ_W'($urandom());
               last_hz   = FREQ_W'($urandom());
               step_word = CSR_W'($urandom());
            end
            default: begin
               base      = noise[0] ? '1 : '0;
               last_hz   = noise[1] ? '1 : '0;
               step_word = noise[2] ? '1 : {3'b111, 27'd0};
            end
         endcase
         r = $urandom_range(0, 9);
         if (shape == 1 || r == 0) thr = -8'sd128;
         else if (r == 1)          thr = 8'sd127;
         else                      thr = 8'($urandom_range(0, 160) - 100);
         load_settings(base, last_hz, step_word, thr);

         running = 1'b0;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            r = $urandom_range(0, 99);
            if (n == 0)                            act = ACT_START;
            else if (r < 2)                        act = ACT_CLEAR;
            else if (r < 5)                        act = ACT_STOP;
            else if (r < 8 || (!running && r < 30)) act = ACT_START;
            else                                   act = ACT_TICK;
            if (act == ACT_START) running = 1'b1;
            if (act == ACT_STOP)  running = 1'b0;
            r = $urandom_range(0, 15);
            if (r == 0)      strength = -8'sd128;
            else if (r == 1) strength = 8'sd127;
            else             strength = 8'($urandom());
            send_word(act, strength);
         end
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && words_outstanding == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ----- sweep_scanner_hit_table.f -----
src/sst_pkg.sv
src/sst_cell.sv
src/sweep_scanner_hit_table.sv
tb/sweep_scanner_hit_table_check.sv
tb/sweep_scanner_hit_table_tb.sv
